// File: design/led_matrix_chain_driver_defines.svh
// Assertion macros for the LED matrix chain driver
`ifndef LED_MATRIX_CHAIN_DRIVER_DEFINES_SVH
`define LED_MATRIX_CHAIN_DRIVER_DEFINES_SVH

// same-cycle implication
`define LMCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmcd assertion failed");

// next-cycle implication
`define LMCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmcd assertion failed");

`endif

// File: design/lmcd_pkg.sv
// Types and constants shared by the LED matrix chain driver
`timescale 1ns / 1ps
package lmcd_pkg;
    localparam int DEVICES_MAX = 8;
    localparam int ROWS        = 8;
    localparam int DEPTH       = DEVICES_MAX * ROWS;
    localparam int AW          = $clog2(DEPTH);
    localparam int RW          = $clog2(ROWS);
    localparam int DCW         = $clog2(DEVICES_MAX);

    localparam logic [2:0] REQ_SET_LED    = 3'd0;
    localparam logic [2:0] REQ_SET_ROW    = 3'd1;
    localparam logic [2:0] REQ_SET_COLUMN = 3'd2;
    localparam logic [2:0] REQ_CLEAR      = 3'd3;
    localparam logic [2:0] REQ_SHUTDOWN   = 3'd4;
    localparam logic [2:0] REQ_INTENSITY  = 3'd5;
    localparam logic [2:0] REQ_SCAN_LIMIT = 3'd6;

    localparam logic [7:0] OPC_INTENSITY = 8'h0A;
    localparam logic [7:0] OPC_SCANLIMIT = 8'h0B;
    localparam logic [7:0] OPC_SHUTDOWN  = 8'h0C;
    localparam logic [7:0] INTENSITY_MAX = 8'd15;
    localparam logic [7:0] SCANLIMIT_MAX = 8'd7;
    localparam logic [7:0] COL0_MASK     = 8'h80;
    localparam logic [7:0] SHUT_RUN      = 8'h01;

    localparam logic [3:0] DEVICE_COUNT_MAX = 4'(DEVICES_MAX);
    localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] device;
        logic [2:0] row;
        logic [2:0] column;
        logic [7:0] value;
    } t_req;

    typedef struct packed {
        logic [15:0] word;
        logic        frame_end;
        logic        last;
    } t_res;

    typedef struct packed {
        logic load_req;
        logic rd_issue;
        logic prep;
        logic emit;
        logic row_next;
    } t_cmd;

    typedef struct packed {
        logic req_ok;
        logic needs_read;
        logic last_word;
        logic last_row;
        logic out_free;
    } t_sts;
endpackage

// File: design/lmcd_intf.sv
// Channel interfaces: command input, word output and configuration write
`timescale 1ns / 1ps
interface lmcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [3:0] device;
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] value;

    modport source (output valid, output req_type, output device, output row,
                    output column, output value, input ready);
    modport sink   (input valid, input req_type, input device, input row,
                    input column, input value, output ready);
endinterface

interface lmcd_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        frame_end;
    logic        last;

    modport source (output valid, output word, output frame_end, output last,
                    input ready);
    modport sink   (input valid, input word, input frame_end, input last,
                    output ready);
endinterface

interface lmcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/led_matrix_chain_driver.sv
// Top level of the LED matrix chain driver
// A command is taken only when the previous one has issued all its words. It passes a
// decode state after the transfer, then per frame a prep state that builds the frame
// word and, for set and clear commands, updates the shadow row (set led and set column
// first read the row from the single-port store in a read state), then an emit state that
// issues one word per chained device in use, held while the one-word output register is full.
// Set column and clear send eight frames, one per row, other commands one; a rejected
// command sends none. The shadow store clears through per-row valid bits at reset, so
// commands are taken right after reset.
`timescale 1ns / 1ps
module led_matrix_chain_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmcd_req_if.sink    i_req,
    lmcd_res_if.source  o_res,
    lmcd_cfg_if.sink    i_cfg
);
    lmcd_pkg::t_req w_req;
    lmcd_pkg::t_res w_res;
    lmcd_pkg::t_cmd w_cmd;
    lmcd_pkg::t_sts w_sts;

    assign w_req.req_type = i_req.req_type;
    assign w_req.device   = i_req.device;
    assign w_req.row      = i_req.row;
    assign w_req.column   = i_req.column;
    assign w_req.value    = i_req.value;
    assign i_cfg.ready    = 1'b1;

    lmcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lmcd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (w_req),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out       (w_res)
    );

    assign o_res.word      = w_res.word;
    assign o_res.frame_end = w_res.frame_end;
    assign o_res.last      = w_res.last;
endmodule

// File: design/lmcd_datapath.sv
// Datapath: shadow row store, frame word generation and output register
`timescale 1ns / 1ps
module lmcd_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmcd_pkg::t_cmd  i_cmd,
    output lmcd_pkg::t_sts  o_sts,
    input  lmcd_pkg::t_req  i_req,
    input  logic            i_cfg_valid,
    input  logic [3:0]      i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lmcd_pkg::t_res  o_out
);
    logic [3:0]                  r_dev_count;
    lmcd_pkg::t_req              r_req;
    logic [lmcd_pkg::RW-1:0]     r_row_idx;
    logic [lmcd_pkg::DCW-1:0]    r_dcnt;
    logic [7:0]                  r_opcode;
    logic [7:0]                  r_data;
    logic [7:0]                  r_mem [lmcd_pkg::DEPTH];
    logic [lmcd_pkg::DEPTH-1:0]  r_vld;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_vld;
    logic                        r_out_valid;
    lmcd_pkg::t_res              r_out;

    logic [3:0]                  ndev;
    logic                        multi;
    logic [lmcd_pkg::RW-1:0]     cur_row;
    logic [lmcd_pkg::AW-1:0]     slot;
    logic [7:0]                  old_data;
    logic [7:0]                  mask;
    logic                        led_on;
    logic [7:0]                  new_data;
    logic [7:0]                  new_opcode;
    logic                        mem_wr;
    logic                        type_ok;

    function automatic logic multi_or_row_write(input logic [2:0] t);
        return (t == lmcd_pkg::REQ_SET_LED) || (t == lmcd_pkg::REQ_SET_ROW) ||
               (t == lmcd_pkg::REQ_SET_COLUMN) || (t == lmcd_pkg::REQ_CLEAR);
    endfunction

    always_comb begin
        if (r_dev_count == 4'd0 || r_dev_count > lmcd_pkg::DEVICE_COUNT_MAX) begin
            ndev = lmcd_pkg::DEVICE_COUNT_MAX;
        end else begin
            ndev = r_dev_count;
        end
    end

    assign multi    = (r_req.req_type == lmcd_pkg::REQ_SET_COLUMN) ||
                      (r_req.req_type == lmcd_pkg::REQ_CLEAR);
    assign cur_row  = multi ? r_row_idx : r_req.row;
    assign slot     = {r_req.device[lmcd_pkg::AW-lmcd_pkg::RW-1:0], cur_row};
    assign old_data = r_rd_vld ? r_rd_data : 8'h00;
    assign mask     = lmcd_pkg::COL0_MASK >> r_req.column;
    assign led_on   = (r_req.req_type == lmcd_pkg::REQ_SET_COLUMN) ?
                      r_req.value[~r_row_idx] : (r_req.value != 8'h00);
    assign mem_wr   = i_cmd.prep && multi_or_row_write(r_req.req_type);

    always_comb begin
        new_data   = r_req.value;
        new_opcode = 8'({1'b0, cur_row} + 4'd1);
        case (r_req.req_type)
            lmcd_pkg::REQ_SET_LED, lmcd_pkg::REQ_SET_COLUMN: begin
                new_data = led_on ? (old_data | mask) : (old_data & ~mask);
            end
            lmcd_pkg::REQ_SET_ROW: begin
                new_data = r_req.value;
            end
            lmcd_pkg::REQ_CLEAR: begin
                new_data = 8'h00;
            end
            lmcd_pkg::REQ_SHUTDOWN: begin
                new_data   = (r_req.value != 8'h00) ? 8'h00 : lmcd_pkg::SHUT_RUN;
                new_opcode = lmcd_pkg::OPC_SHUTDOWN;
            end
            lmcd_pkg::REQ_INTENSITY: begin
                new_opcode = lmcd_pkg::OPC_INTENSITY;
            end
            lmcd_pkg::REQ_SCAN_LIMIT: begin
                new_opcode = lmcd_pkg::OPC_SCANLIMIT;
            end
            default: begin
                new_data = r_req.value;
            end
        endcase
    end

    always_comb begin
        case (r_req.req_type)
            lmcd_pkg::REQ_INTENSITY:  type_ok = (r_req.value <= lmcd_pkg::INTENSITY_MAX);
            lmcd_pkg::REQ_SCAN_LIMIT: type_ok = (r_req.value <= lmcd_pkg::SCANLIMIT_MAX);
            lmcd_pkg::REQ_SET_LED, lmcd_pkg::REQ_SET_ROW, lmcd_pkg::REQ_SET_COLUMN,
            lmcd_pkg::REQ_CLEAR, lmcd_pkg::REQ_SHUTDOWN: type_ok = 1'b1;
            default:                  type_ok = 1'b0;
        endcase
    end

    assign o_sts.req_ok     = type_ok && (r_req.device < ndev);
    assign o_sts.needs_read = (r_req.req_type == lmcd_pkg::REQ_SET_LED) ||
                              (r_req.req_type == lmcd_pkg::REQ_SET_COLUMN);
    assign o_sts.last_word  = (r_dcnt == '0);
    assign o_sts.last_row   = !multi || (r_row_idx == lmcd_pkg::ROW_LAST);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= lmcd_pkg::DEVICE_COUNT_MAX;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dev_count <= i_cfg_data;
            end
            if (mem_wr) begin
                r_vld[slot] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[slot] <= new_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[slot];
            r_rd_vld  <= r_vld[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req     <= i_req;
            r_row_idx <= '0;
        end else if (i_cmd.row_next) begin
            r_row_idx <= r_row_idx + 1'b1;
        end
        if (i_cmd.prep) begin
            r_opcode <= new_opcode;
            r_data   <= new_data;
            r_dcnt   <= lmcd_pkg::DCW'(ndev - 4'd1);
        end else if (i_cmd.emit && !o_sts.last_word) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.word      <= ({1'b0, r_dcnt} == r_req.device) ?
                               {r_opcode, r_data} : 16'h0000;
            r_out.frame_end <= o_sts.last_word;
            r_out.last      <= o_sts.last_word && o_sts.last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// File: design/lmcd_ctrl.sv
// Controller: sequences decode, read-modify-write and frame emission
`timescale 1ns / 1ps
`include "led_matrix_chain_driver_defines.svh"
module lmcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lmcd_pkg::t_sts  i_sts,
    output lmcd_pkg::t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_PREP  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.req_ok) begin
                    n_state = S_IDLE;
                end else if (i_sts.needs_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_word) begin
                    if (i_sts.last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.row_next = 1'b1;
                        n_state        = i_sts.needs_read ? S_READ : S_PREP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LMCD_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)
    `LMCD_ASSERT_NXT(a_accept_check, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK)
    `LMCD_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, (r_state == S_EMIT) && i_sts.out_free && i_sts.last_word && i_sts.last_row, o_in_ready)
    `LMCD_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.load_req, o_cmd.rd_issue, o_cmd.prep, o_cmd.emit}))
endmodule

// File: bench/tb_led_matrix_chain_driver.sv
// Testbench for the LED matrix chain driver: directed and random commands against a frame predictor
`timescale 1ns / 1ps
module tb_led_matrix_chain_driver;
    import lmcd_pkg::*;

    localparam logic [2:0] REQ_UNKNOWN = 3'd7;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 32;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASE_ITEMS    = 54;
    localparam int unsigned PRESS_PHASE    = 4;
    localparam int unsigned ERR_PRINT_MAX  = 40;

    class chain_scoreboard;
        logic [7:0]  row_image [DEPTH];
        logic [3:0]  dev_count;
        t_res        words_due [$];
        int unsigned errors;

        function new();
            foreach (row_image[i]) row_image[i] = 8'h00;
            dev_count = DEVICE_COUNT_MAX;
            errors    = 0;
        endfunction

        function void set_count(logic [3:0] v);
            dev_count = v;
        endfunction

        function int unsigned pending();
            return words_due.size();
        endfunction

        function int unsigned devices_in_use();
            if (dev_count == 4'd0 || dev_count > DEVICE_COUNT_MAX) begin
                return DEVICES_MAX;
            end
            return dev_count;
        endfunction

        function void add_frame(int unsigned ndev, int unsigned target, logic [7:0] opc,
                                logic [7:0] data);
            t_res w;
            int   d;
            for (d = int'(ndev) - 1; d >= 0; d--) begin
                w.word      = (d == int'(target)) ? {opc, data} : 16'h0000;
                w.frame_end = (d == 0);
                w.last      = 1'b0;
                words_due.push_back(w);
            end
        endfunction

        function void led_write(int unsigned ndev, int unsigned dev, int unsigned row,
                                int unsigned col, bit on);
            int unsigned idx;
            logic [7:0]  mask;
            idx  = dev * ROWS + row;
            mask = COL0_MASK >> col;
            if (on) begin
                row_image[idx] = row_image[idx] | mask;
            end else begin
                row_image[idx] = row_image[idx] & ~mask;
            end
            add_frame(ndev, dev, 8'(row) + 8'd1, row_image[idx]);
        endfunction

        function void note_command(t_req r);
            int unsigned ndev;
            int unsigned dev;
            int unsigned n0;
            int unsigned ri;
            t_res        w;
            ndev = devices_in_use();
            dev  = r.device;
            if (dev >= ndev) return;
            n0 = words_due.size();
            case (r.req_type)
                REQ_SET_LED: begin
                    led_write(ndev, dev, r.row, r.column, r.value != 8'h00);
                end
                REQ_SET_ROW: begin
                    row_image[dev * ROWS + r.row] = r.value;
                    add_frame(ndev, dev, 8'(r.row) + 8'd1, r.value);
                end
                REQ_SET_COLUMN: begin
                    for (ri = 0; ri < ROWS; ri++) begin
                        led_write(ndev, dev, ri, r.column, r.value[7 - ri]);
                    end
                end
                REQ_CLEAR: begin
                    for (ri = 0; ri < ROWS; ri++) begin
                        row_image[dev * ROWS + ri] = 8'h00;
                        add_frame(ndev, dev, 8'(ri) + 8'd1, 8'h00);
                    end
                end
                REQ_SHUTDOWN: begin
                    add_frame(ndev, dev, OPC_SHUTDOWN, (r.value != 8'h00) ? 8'h00 : SHUT_RUN);
                end
                REQ_INTENSITY: begin
                    if (r.value <= INTENSITY_MAX) add_frame(ndev, dev, OPC_INTENSITY, r.value);
                end
                REQ_SCAN_LIMIT: begin
                    if (r.value <= SCANLIMIT_MAX) add_frame(ndev, dev, OPC_SCANLIMIT, r.value);
                end
                default: begin
                end
            endcase
            if (words_due.size() > n0) begin
                w = words_due.pop_back();
                w.last = 1'b1;
                words_due.push_back(w);
            end
        endfunction

        task report(string what, t_res got, t_res want);
            errors++;
            if (errors <= ERR_PRINT_MAX) begin
                $display("%0t mismatch %s: got word %h end %b last %b, want %h %b %b", $time,
                         what, got.word, got.frame_end, got.last, want.word, want.frame_end,
                         want.last);
            end
        endtask

        task check_word(t_res got);
            t_res want;
            if (words_due.size() == 0) begin
                want = '0;
                report("unexpected word", got, want);
            end else begin
                want = words_due.pop_front();
                if (got.word !== want.word || got.frame_end !== want.frame_end ||
                    got.last !== want.last) begin
                    report("field", got, want);
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   hold_res_req = 1'b0;
    bit   sender_gaps  = 1'b1;
    int unsigned     idle_run = 0;
    chain_scoreboard sb;

    lmcd_req_if req_ch ();
    lmcd_res_if res_ch ();
    lmcd_cfg_if cfg_ch ();

    led_matrix_chain_driver i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req mk_req(logic [2:0] kind, logic [3:0] dev, logic [2:0] row,
                                    logic [2:0] col, logic [7:0] val);
        t_req r;
        r.req_type = kind;
        r.device   = dev;
        r.row      = row;
        r.column   = col;
        r.value    = val;
        return r;
    endfunction

    function automatic t_req random_command(int unsigned ndev);
        t_req        r;
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 4)       r.req_type = REQ_UNKNOWN;
        else if (p < 34) r.req_type = REQ_SET_LED;
        else if (p < 54) r.req_type = REQ_SET_ROW;
        else if (p < 66) r.req_type = REQ_SET_COLUMN;
        else if (p < 72) r.req_type = REQ_CLEAR;
        else if (p < 80) r.req_type = REQ_SHUTDOWN;
        else if (p < 90) r.req_type = REQ_INTENSITY;
        else             r.req_type = REQ_SCAN_LIMIT;
        if ($urandom_range(0, 9) == 0) begin
            r.device = 4'($urandom_range(0, 15));
        end else begin
            r.device = 4'($urandom_range(0, ndev - 1));
        end
        r.row    = 3'($urandom_range(0, 7));
        r.column = 3'($urandom_range(0, 7));
        r.value  = 8'($urandom_range(0, 255));
        if (r.req_type == REQ_INTENSITY && $urandom_range(0, 3) != 0) begin
            r.value = 8'($urandom_range(0, 15));
        end else if (r.req_type == REQ_SCAN_LIMIT && $urandom_range(0, 3) != 0) begin
            r.value = 8'($urandom_range(0, 7));
        end else if (r.req_type == REQ_SET_LED && $urandom_range(0, 1) == 0) begin
            r.value = 8'($urandom_range(0, 1));
        end
        return r;
    endfunction

    // enter and leave at a falling edge
    task send_req(t_req r);
        int unsigned g;
        g = sender_gaps ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.device   <= r.device;
        req_ch.row      <= r.row;
        req_ch.column   <= r.column;
        req_ch.value    <= r.value;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        sb.note_command(r);
        @(negedge clk);
    endtask

    task write_count(logic [3:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.set_count(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task settle_idle();
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : res_side
        int unsigned stall_left;
        int unsigned free_left;
        int unsigned hold_left;
        t_res        got;
        stall_left   = 0;
        free_left    = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_res_req) begin
                hold_res_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 63) == 0) begin
                    free_left = $urandom_range(50, 200);
                end else begin
                    stall_left = gap_len();
                end
            end
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got.word      = res_ch.word;
                got.frame_end = res_ch.frame_end;
                got.last      = res_ch.last;
                sb.check_word(got);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_run = 0;
        end else begin
            idle_run = idle_run + 1;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("tb_led_matrix_chain_driver: done, errors");
            $finish;
        end
    end

    initial begin : cmd_side
        t_req        opening [$];
        logic [3:0]  count_plan [6];
        int unsigned ph;
        int unsigned k;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.device   = '0;
        req_ch.row      = '0;
        req_ch.column   = '0;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        sb = new();
        count_plan = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd6};

        opening.push_back(mk_req(REQ_SET_LED,    4'd0,  3'd0, 3'd0, 8'h01));
        opening.push_back(mk_req(REQ_SET_LED,    4'd7,  3'd7, 3'd7, 8'hFF));
        opening.push_back(mk_req(REQ_SET_ROW,    4'd3,  3'd5, 3'd0, 8'hA5));
        opening.push_back(mk_req(REQ_SET_LED,    4'd3,  3'd5, 3'd0, 8'h00));
        opening.push_back(mk_req(REQ_SET_LED,    4'd3,  3'd5, 3'd1, 8'h40));
        opening.push_back(mk_req(REQ_SET_COLUMN, 4'd7,  3'd0, 3'd0, 8'hFF));
        opening.push_back(mk_req(REQ_SET_COLUMN, 4'd7,  3'd7, 3'd7, 8'h5A));
        opening.push_back(mk_req(REQ_SET_COLUMN, 4'd0,  3'd3, 3'd0, 8'h00));
        opening.push_back(mk_req(REQ_CLEAR,      4'd7,  3'd0, 3'd0, 8'h00));
        opening.push_back(mk_req(REQ_CLEAR,      4'd0,  3'd7, 3'd7, 8'hFF));
        opening.push_back(mk_req(REQ_SHUTDOWN,   4'd5,  3'd0, 3'd0, 8'h00));
        opening.push_back(mk_req(REQ_SHUTDOWN,   4'd5,  3'd0, 3'd0, 8'hFF));
        opening.push_back(mk_req(REQ_INTENSITY,  4'd2,  3'd0, 3'd0, 8'd0));
        opening.push_back(mk_req(REQ_INTENSITY,  4'd2,  3'd0, 3'd0, 8'd15));
        opening.push_back(mk_req(REQ_INTENSITY,  4'd2,  3'd0, 3'd0, 8'd16));
        opening.push_back(mk_req(REQ_INTENSITY,  4'd2,  3'd0, 3'd0, 8'hFF));
        opening.push_back(mk_req(REQ_SCAN_LIMIT, 4'd6,  3'd0, 3'd0, 8'd7));
        opening.push_back(mk_req(REQ_SCAN_LIMIT, 4'd6,  3'd0, 3'd0, 8'd8));
        opening.push_back(mk_req(REQ_SCAN_LIMIT, 4'd6,  3'd0, 3'd0, 8'h80));
        opening.push_back(mk_req(REQ_UNKNOWN,    4'd1,  3'd0, 3'd0, 8'h11));
        opening.push_back(mk_req(REQ_SET_ROW,    4'd8,  3'd0, 3'd0, 8'hFF));
        opening.push_back(mk_req(REQ_SET_ROW,    4'd15, 3'd7, 3'd7, 8'hFF));
        opening.push_back(mk_req(REQ_SET_ROW,    4'd0,  3'd7, 3'd0, 8'hFF));
        opening.push_back(mk_req(REQ_SCAN_LIMIT, 4'd0,  3'd0, 3'd0, 8'd0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i]) send_req(opening[i]);
        req_ch.valid <= 1'b0;

        for (ph = 0; ph < 6; ph++) begin
            settle_idle();
            write_count(count_plan[ph]);
            sender_gaps = (ph != 2 && ph != PRESS_PHASE);
            if (ph == PRESS_PHASE) hold_res_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_req(random_command(sb.devices_in_use()));
            end
            req_ch.valid <= 1'b0;
        end

        settle_idle();
        if (sb.errors == 0) begin
            $display("tb_led_matrix_chain_driver: done, clean");
        end else begin
            $display("tb_led_matrix_chain_driver: done, errors");
        end
        $finish;
    end
endmodule
